@@ src/srt_pkg.sv @@
// Shared constants, codes and types of the section address translator.
package srt_pkg;

	// Default number of section table entries.
	localparam int NUM_SECTIONS_DEF = 16;

	// Fixed field widths.
	localparam int ADDR_W  = 32;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;

	// Codes carried by the mode field of a request beat.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_XLATE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_MAPPED   = 2'd0,
		ST_UNMAPPED = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Write port of the section table: one entry with its precomputed range end.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W:0]   lim;
		logic [ADDR_W-1:0] fstart;
	} tbl_wr_t;

	// A searched translation on its way to the offset adder.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [SLOT_W-1:0] entry;
		logic [ADDR_W-1:0] diff;
		logic [ADDR_W-1:0] fstart;
	} hit_t;

endpackage

@@ src/srt_ifs.sv @@
// Handshake channel interfaces of the section address translator.

// Request channel: section loads and address translations.
interface srt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [srt_pkg::SLOT_W-1:0]  entry_index;
	logic [srt_pkg::ADDR_W-1:0]  section_base;
	logic [srt_pkg::ADDR_W-1:0]  section_virtual_size;
	logic [srt_pkg::ADDR_W-1:0]  section_raw_size;
	logic [srt_pkg::ADDR_W-1:0]  section_file_start;
	logic [srt_pkg::ADDR_W-1:0]  lookup_address;

	modport source (
		output valid, mode, entry_index, section_base, section_virtual_size,
		       section_raw_size, section_file_start, lookup_address,
		input  ready
	);
	modport sink (
		input  valid, mode, entry_index, section_base, section_virtual_size,
		       section_raw_size, section_file_start, lookup_address,
		output ready
	);
endinterface

// Response channel: one beat per translation.
interface srt_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [srt_pkg::ADDR_W-1:0]  file_position;
	logic [srt_pkg::SLOT_W-1:0]  matched_entry;

	modport source (
		output valid, status, file_position, matched_entry,
		input  ready
	);
	modport sink (
		input  valid, status, file_position, matched_entry,
		output ready
	);
endinterface

// Configuration write channel for the section count register.
interface srt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [srt_pkg::COUNT_W-1:0] search_count;

	modport source (
		output valid, search_count,
		input  ready
	);
	modport sink (
		input  valid, search_count,
		output ready
	);
endinterface

@@ src/srt_table.sv @@
// Section table storage with one range comparator lane per entry.
module srt_table #(
	parameter int NUM = srt_pkg::NUM_SECTIONS_DEF,
	localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1
) (
	input  logic                        clk,
	input  srt_pkg::tbl_wr_t            wr,
	input  logic [srt_pkg::COUNT_W-1:0] count,
	input  logic [srt_pkg::ADDR_W-1:0]  addr,
	output logic [NUM-1:0]              hit,
	input  logic [IDX_W-1:0]            rd_idx,
	output logic [srt_pkg::ADDR_W-1:0]  rd_base,
	output logic [srt_pkg::ADDR_W-1:0]  rd_fstart
);
	import srt_pkg::*;

	logic [ADDR_W-1:0] base_q   [NUM];
	logic [ADDR_W:0]   lim_q    [NUM];
	logic [ADDR_W-1:0] fstart_q [NUM];

	// Entry write; slots beyond the table are dropped.
	always_ff @(posedge clk) begin
		if (wr.en && (int'(wr.slot) < NUM)) begin
			base_q[IDX_W'(wr.slot)]   <= wr.base;
			lim_q[IDX_W'(wr.slot)]    <= wr.lim;
			fstart_q[IDX_W'(wr.slot)] <= wr.fstart;
		end
	end

	// Each lane tests its own entry; lanes at or above the count stay quiet.
	for (genvar i = 0; i < NUM; i++) begin : g_lane
		assign hit[i] = (i < int'(count)) && (addr >= base_q[i]) &&
		                ({1'b0, addr} < lim_q[i]);
	end

	// Read of the chosen entry for the offset calculation.
	assign rd_base   = base_q[rd_idx];
	assign rd_fstart = fstart_q[rd_idx];

endmodule

@@ src/srt_resolve.sv @@
// Offset adder and output register stages of the section address translator.
module srt_resolve (
	input  logic                       clk,
	input  logic                       arst_n,
	input  srt_pkg::hit_t              in,
	output logic                       take,
	input  logic                       out_ready,
	output logic                       out_valid,
	output srt_pkg::status_t           status,
	output logic [srt_pkg::ADDR_W-1:0] file_position,
	output logic [srt_pkg::SLOT_W-1:0] matched_entry
);
	import srt_pkg::*;

	logic              v_s4;
	logic              found_s4;
	logic [SLOT_W-1:0] entry_s4;
	logic [ADDR_W-1:0] diff_s4;
	logic [ADDR_W-1:0] fstart_s4;
	logic              v_s5;
	logic              mv5;
	logic [ADDR_W:0]   sum;

	// Flow control: the output register frees up when its beat is taken.
	assign mv5  = !v_s5 || out_ready;
	assign take = !v_s4 || mv5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (take) v_s4 <= in.valid;
			if (mv5) v_s5 <= v_s4;
		end
	end

	// Stage four holds the matched entry's file start and the address distance.
	always_ff @(posedge clk) begin
		if (take) begin
			found_s4  <= in.found;
			entry_s4  <= in.entry;
			diff_s4   <= in.diff;
			fstart_s4 <= in.fstart;
		end
	end

	// The offset is summed in 33 bits so that a carry shows an overflow.
	assign sum = {1'b0, fstart_s4} + {1'b0, diff_s4};

	always_ff @(posedge clk) begin
		if (mv5 && v_s4) begin
			matched_entry <= found_s4 ? entry_s4 : '0;
			if (!found_s4) begin
				status        <= ST_UNMAPPED;
				file_position <= '0;
			end else if (sum[ADDR_W]) begin
				status        <= ST_OVERFLOW;
				file_position <= '0;
			end else begin
				status        <= ST_MAPPED;
				file_position <= sum[ADDR_W-1:0];
			end
		end
	end

	assign out_valid = v_s5;

endmodule

@@ src/section_rva_translator.sv @@
// Top level of the section address translator: table search pipeline and control.
// A translation passes stages one to three and stage four before its response beat is valid.
// Throughput: one translation per cycle while the response side takes beats; a load holds in
// stage one until no translation remains in stages two and three.
// Reset clears all stage valid bits and sets the section count to zero; the table
// contents are undefined until loaded and no clearing pass runs.
module section_rva_translator #(
	parameter int NUM_SECTIONS = srt_pkg::NUM_SECTIONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srt_cfg_if.sink   cfg,
	srt_in_if.sink    req,
	srt_out_if.source rsp
);
	import srt_pkg::*;

	localparam int IDX_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

	logic [COUNT_W-1:0]      count_q;

	logic                    v_s1;
	logic                    mode_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic [ADDR_W-1:0]       base_s1;
	logic [ADDR_W-1:0]       size_s1;
	logic [ADDR_W-1:0]       fstart_s1;
	logic [ADDR_W-1:0]       addr_s1;

	logic                    v_s2;
	logic [NUM_SECTIONS-1:0] hit_s2;
	logic [ADDR_W-1:0]       addr_s2;

	logic                    v_s3;
	logic                    found_s3;
	logic [IDX_W-1:0]        idx_s3;
	logic [ADDR_W-1:0]       addr_s3;

	logic [NUM_SECTIONS-1:0] hit;
	logic [NUM_SECTIONS-1:0] first_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic [ADDR_W-1:0]       rd_base;
	logic [ADDR_W-1:0]       rd_fstart;
	logic                    load_ok;
	logic                    s1_go;
	logic                    acc2;
	logic                    acc3;
	logic                    take;
	tbl_wr_t                 wr;
	hit_t                    s3_out;
	status_t                 status;

	// Section count register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.search_count;
		end
	end

	// Stage handshake: each stage accepts when empty or when it moves on.
	assign acc3    = !v_s3 || take;
	assign acc2    = !v_s2 || acc3;
	assign load_ok = !v_s2 && !v_s3;
	assign s1_go   = v_s1 && ((mode_s1 == MODE_LOAD) ? load_ok : acc2);
	assign req.ready = !v_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (req.ready) v_s1 <= req.valid;
			if (acc2) v_s2 <= v_s1 && (mode_s1 == MODE_XLATE);
			if (acc3) v_s3 <= v_s2;
		end
	end

	// Stage one: the request beat, with the larger of the two section sizes.
	always_ff @(posedge clk) begin
		if (req.ready) begin
			mode_s1   <= req.mode;
			slot_s1   <= req.entry_index;
			base_s1   <= req.section_base;
			size_s1   <= (req.section_virtual_size > req.section_raw_size) ?
			             req.section_virtual_size : req.section_raw_size;
			fstart_s1 <= req.section_file_start;
			addr_s1   <= req.lookup_address;
		end
	end

	// A load writes its entry as it leaves stage one.
	assign wr.en     = v_s1 && (mode_s1 == MODE_LOAD) && load_ok;
	assign wr.slot   = slot_s1;
	assign wr.base   = base_s1;
	assign wr.lim    = {1'b0, base_s1} + {1'b0, size_s1};
	assign wr.fstart = fstart_s1;

	srt_table #(
		.NUM (NUM_SECTIONS)
	) u_table (
		.clk       (clk),
		.wr        (wr),
		.count     (count_q),
		.addr      (addr_s1),
		.hit       (hit),
		.rd_idx    (idx_s3),
		.rd_base   (rd_base),
		.rd_fstart (rd_fstart)
	);

	// Stage two: the lane match vector.
	always_ff @(posedge clk) begin
		if (acc2) begin
			hit_s2  <= hit;
			addr_s2 <= addr_s1;
		end
	end

	// Lowest matching entry wins; isolate it and encode its index.
	assign first_s2 = hit_s2 & (~hit_s2 + NUM_SECTIONS'(1));

	always_comb begin
		idx_s2 = '0;
		for (int i = 0; i < NUM_SECTIONS; i++) begin
			if (first_s2[i]) idx_s2 = idx_s2 | IDX_W'(i);
		end
	end

	// Stage three: the chosen entry is read and its distance from the base taken.
	always_ff @(posedge clk) begin
		if (acc3) begin
			found_s3 <= |hit_s2;
			idx_s3   <= idx_s2;
			addr_s3  <= addr_s2;
		end
	end

	assign s3_out.valid  = v_s3;
	assign s3_out.found  = found_s3;
	assign s3_out.entry  = SLOT_W'(idx_s3);
	assign s3_out.diff   = addr_s3 - rd_base;
	assign s3_out.fstart = rd_fstart;

	srt_resolve u_resolve (
		.clk           (clk),
		.arst_n        (arst_n),
		.in            (s3_out),
		.take          (take),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.status        (status),
		.file_position (rsp.file_position),
		.matched_entry (rsp.matched_entry)
	);

	assign rsp.status = status;

	// At most one entry is picked from the match vector.
	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0(first_s2) && ((|first_s2) == (|hit_s2)))
		else $error("priority pick is not one-hot");

	// Stage two only fills from a translation leaving stage one.
	a_s2_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1 && (mode_s1 == MODE_XLATE)))
		else $error("stage two filled without a translation");

	// The table is never rewritten while a translation still reads it.
	a_no_write_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !take |=> !$past(wr.en) && $stable(idx_s3))
		else $error("table written under a waiting translation");

	// A held load cannot sit forever behind an empty search path.
	a_load_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (mode_s1 == MODE_LOAD) && !v_s2 && !v_s3 |=> !v_s1 || req.ready)
		else $error("load stalled with no translation ahead");

endmodule

@@ bench/tb_section_rva_translator.sv @@
// Self-checking testbench of the section address translator: loads, lookups and counts.
module tb_section_rva_translator;
	import srt_pkg::*;

	localparam int NUM_SLOTS       = NUM_SECTIONS_DEF;
	localparam int DRAIN_CYCLES    = 8;
	localparam int QUIET_LIMIT     = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS     = 180;
	localparam int NUM_PHASES      = 10;

	// One request beat as the sender sees it.
	typedef struct {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] vsize;
		logic [ADDR_W-1:0] rsize;
		logic [ADDR_W-1:0] fstart;
		logic [ADDR_W-1:0] addr;
	} section_req_t;

	// One translation outcome.
	typedef struct {
		status_t           status;
		logic [ADDR_W-1:0] file_position;
		logic [SLOT_W-1:0] matched_entry;
	} offset_result_t;

	// Keeps a shadow of the section table and the count, and the offsets still owed.
	class file_offset_predictor;
		logic [ADDR_W-1:0] base_tab   [NUM_SECTIONS_DEF];
		logic [ADDR_W-1:0] vsize_tab  [NUM_SECTIONS_DEF];
		logic [ADDR_W-1:0] rsize_tab  [NUM_SECTIONS_DEF];
		logic [ADDR_W-1:0] fstart_tab [NUM_SECTIONS_DEF];
		logic [COUNT_W-1:0] search_count;
		offset_result_t expected_offsets[$];
		int faults;
		int loads_seen;
		int xlates_seen;
		int status_seen[3];

		function new();
			search_count = '0;
			faults = 0;
			loads_seen = 0;
			xlates_seen = 0;
			status_seen = '{0, 0, 0};
		endfunction

		function void set_count(logic [COUNT_W-1:0] count);
			search_count = count;
		endfunction

		// A count above the table depth searches the whole table.
		function int searched_entries();
			return (search_count > NUM_SECTIONS_DEF) ? NUM_SECTIONS_DEF :
				int'(search_count);
		endfunction

		function int outstanding();
			return expected_offsets.size();
		endfunction

		// Loads update the shadow table; translations queue the offset they must give.
		function void note_request(section_req_t r);
			offset_result_t res;
			logic [ADDR_W-1:0] span;
			logic [ADDR_W:0] span_end;
			logic [ADDR_W:0] sum;
			int i;
			if (r.mode == MODE_LOAD) begin
				base_tab[r.slot] = r.base;
				vsize_tab[r.slot] = r.vsize;
				rsize_tab[r.slot] = r.rsize;
				fstart_tab[r.slot] = r.fstart;
				loads_seen++;
				return;
			end
			res.status = ST_UNMAPPED;
			res.file_position = '0;
			res.matched_entry = '0;
			for (i = 0; i < searched_entries(); i++) begin
				span = (vsize_tab[i] > rsize_tab[i]) ? vsize_tab[i] : rsize_tab[i];
				span_end = {1'b0, base_tab[i]} + {1'b0, span};
				if (r.addr >= base_tab[i] && {1'b0, r.addr} < span_end) begin
					sum = {1'b0, fstart_tab[i]} + {1'b0, r.addr - base_tab[i]};
					res.matched_entry = i[SLOT_W-1:0];
					if (sum[ADDR_W]) begin
						res.status = ST_OVERFLOW;
					end else begin
						res.status = ST_MAPPED;
						res.file_position = sum[ADDR_W-1:0];
					end
					break;
				end
			end
			status_seen[res.status]++;
			xlates_seen++;
			expected_offsets = {expected_offsets, res};
		endfunction

		// Compares a response beat with the oldest owed offset.
		function void check_response(logic [1:0] status, logic [ADDR_W-1:0] file_position,
				logic [SLOT_W-1:0] matched_entry);
			offset_result_t exp;
			if (expected_offsets.size() == 0) begin
				$error("unexpected response beat: status %0d, file_position %h, %s %0d",
					status, file_position, "matched_entry", matched_entry);
				faults++;
				return;
			end
			exp = expected_offsets.pop_front();
			if (status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, status);
				faults++;
			end
			if (file_position !== exp.file_position) begin
				$error("file_position: expected %h, actual %h", exp.file_position,
					file_position);
				faults++;
			end
			if (matched_entry !== exp.matched_entry) begin
				$error("matched_entry: expected %0d, actual %0d", exp.matched_entry,
					matched_entry);
				faults++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	srt_cfg_if cfg_ch ();
	srt_in_if  req_ch ();
	srt_out_if rsp_ch ();

	file_offset_predictor predictor = new();

	// Idling controls shared between the stimulus and the response side.
	bit source_steady;
	bit sink_steady;
	bit hold_off_request;
	int hold_off_total;
	int counts_written;

	section_rva_translator #(
		.NUM_SECTIONS(NUM_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Free-running clock, period 4.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one; none in a steady stretch.
	function automatic int pick_gap(input bit steady);
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic section_req_t make_load(input logic [SLOT_W-1:0] slot,
			input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] vsize,
			input logic [ADDR_W-1:0] rsize, input logic [ADDR_W-1:0] fstart);
		section_req_t r;
		r.mode = MODE_LOAD;
		r.slot = slot;
		r.base = base;
		r.vsize = vsize;
		r.rsize = rsize;
		r.fstart = fstart;
		r.addr = $urandom;
		return r;
	endfunction

	// The load fields of a translation beat carry random noise.
	function automatic section_req_t make_lookup(input logic [ADDR_W-1:0] addr);
		section_req_t r;
		r.mode = MODE_XLATE;
		r.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
		r.base = $urandom;
		r.vsize = $urandom;
		r.rsize = $urandom;
		r.fstart = $urandom;
		r.addr = addr;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] random_size();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(1, 32'h2000);
		endcase
	endfunction

	// Sections cluster low or high so that ranges overlap and reach the top of the space.
	function automatic section_req_t random_section();
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] fstart;
		case ($urandom_range(0, 3))
			0, 1: base = $urandom;
			2: base = $urandom_range(0, 32'h0001_0000);
			default: base = 32'hFFFF_FFFF - $urandom_range(0, 32'h0001_0000);
		endcase
		case ($urandom_range(0, 6))
			0, 1: fstart = $urandom;
			2: fstart = 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: fstart = $urandom_range(0, 32'h0100_0000);
		endcase
		return make_load(SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), base, random_size(),
			random_size(), fstart);
	endfunction

	// Addresses aimed at a searched section, at its edges, or anywhere at all.
	function automatic logic [ADDR_W-1:0] pick_lookup_address();
		int unsigned roll;
		int unsigned slot;
		logic [ADDR_W-1:0] base;
		longint unsigned size;
		longint unsigned room;
		longint unsigned span;
		longint unsigned offset;
		roll = $urandom_range(0, 99);
		if (predictor.searched_entries() == 0 || roll < 20)
			return $urandom;
		slot = $urandom_range(0, predictor.searched_entries() - 1);
		base = predictor.base_tab[slot];
		size = 64'((predictor.vsize_tab[slot] > predictor.rsize_tab[slot]) ?
			predictor.vsize_tab[slot] : predictor.rsize_tab[slot]);
		room = 64'h1_0000_0000 - 64'(base);
		span = (size < room) ? size : room;
		if (roll < 28)
			return base - 1;
		if (roll < 36)
			return 32'(base + size);
		if (span == 0)
			return $urandom;
		if (roll < 46)
			return base;
		if (roll < 56)
			return 32'(base + span - 1);
		offset = {$urandom, $urandom};
		return 32'(base + offset % span);
	endfunction

	// Offers one request beat after a random gap and waits for it to be taken.
	task automatic offer_beat(input section_req_t r);
		int gap;
		gap = pick_gap(source_steady);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= r.mode;
		req_ch.entry_index <= r.slot;
		req_ch.section_base <= r.base;
		req_ch.section_virtual_size <= r.vsize;
		req_ch.section_raw_size <= r.rsize;
		req_ch.section_file_start <= r.fstart;
		req_ch.lookup_address <= r.addr;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predictor.note_request(r);
	endtask

	// Lets every owed response arrive, then covers a trailing load still in flight.
	task automatic drain_pipeline();
		req_ch.valid <= 1'b0;
		while (predictor.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_section_count(input logic [COUNT_W-1:0] count);
		drain_pipeline();
		cfg_ch.valid <= 1'b1;
		cfg_ch.search_count <= count;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		predictor.set_count(count);
		counts_written++;
	endtask

	// A random phase: mostly translations aimed at the loaded table, some reloads.
	task automatic run_phase(input logic [COUNT_W-1:0] count, input bit src_steady,
			input bit snk_steady, input bit squeeze);
		int n;
		write_section_count(count);
		source_steady = src_steady;
		sink_steady = snk_steady;
		if (squeeze)
			hold_off_request = 1'b1;
		for (n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(0, 3) == 0)
				offer_beat(random_section());
			else
				offer_beat(make_lookup(pick_lookup_address()));
		end
	endtask

	// Response side: takes beats, checks them and stalls at random or on request.
	initial begin : response_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				predictor.check_response(rsp_ch.status, rsp_ch.file_position,
					rsp_ch.matched_entry);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
				hold_off_total += HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				stall_left = pick_gap(sink_steady);
				rsp_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Ends the run when no beat moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No beat accepted for %0d cycles; %0d responses still owed.", QUIET_LIMIT,
			predictor.outstanding());
		$display("section_rva_translator regression: fail");
		$finish;
	end

	// Main sequence: reset, directed table and lookups, then random phases.
	initial begin : stimulus
		logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
		int i;
		arst_n = 1'b0;
		source_steady = 1'b0;
		sink_steady = 1'b0;
		hold_off_request = 1'b0;
		hold_off_total = 0;
		counts_written = 0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.search_count <= '0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_LOAD;
		req_ch.entry_index <= '0;
		req_ch.section_base <= '0;
		req_ch.section_virtual_size <= '0;
		req_ch.section_raw_size <= '0;
		req_ch.section_file_start <= '0;
		req_ch.lookup_address <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no sections searched every address is unmapped.
		write_section_count(5'd0);
		offer_beat(make_lookup(32'h0000_0000));
		offer_beat(make_lookup(32'hFFFF_FFFF));

		// Directed table: raw size wider than virtual, a shadowed overlap, a range running
		// past the top of the address space, an offset at the 32-bit edge, an empty section.
		offer_beat(make_load(4'd0, 32'h0000_1000, 32'h0000_0200, 32'h0000_0400, 32'h0000_0400));
		offer_beat(make_load(4'd1, 32'h0000_1000, 32'h0000_1000, 32'h0000_0010, 32'h0000_8000));
		offer_beat(make_load(4'd2, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0100));
		offer_beat(make_load(4'd3, 32'h0010_0000, 32'h0000_1000, 32'h0000_1000, 32'hFFFF_FF00));
		offer_beat(make_load(4'd4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
		for (i = 5; i < NUM_SLOTS - 1; i++)
			offer_beat(make_load(SLOT_W'(i), 32'h2000_0000 + i * 32'h0001_0000, 32'h0000_8000,
				32'h0000_0100, i * 32'h0000_1000));
		offer_beat(make_load(4'd15, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000));

		write_section_count(5'd16);
		offer_beat(make_lookup(32'h0000_1000));
		offer_beat(make_lookup(32'h0000_13FF));
		offer_beat(make_lookup(32'h0000_1400));
		offer_beat(make_lookup(32'hFFFF_FFFF));
		offer_beat(make_lookup(32'h0010_00FF));
		offer_beat(make_lookup(32'h0010_0100));
		offer_beat(make_lookup(32'h0000_0000));
		offer_beat(make_lookup(32'h9000_0000));

		// Counts include both extremes and values past the table depth.
		phase_counts = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd16, 5'd8, 5'd3, 5'd12, 5'd16};
		phase_counts[6] = COUNT_W'($urandom_range(2, 15));
		phase_counts[8] = COUNT_W'($urandom_range(2, 15));
		for (i = 0; i < NUM_PHASES; i++)
			run_phase(phase_counts[i], i == 2 || i == 5 || i == 7, i == 2 || i == 8, i == 5);

		drain_pipeline();
		$display("Covered %0d section loads and %0d translations over %0d count settings.",
			predictor.loads_seen, predictor.xlates_seen, counts_written);
		$display("Outcomes: %0d mapped, %0d not mapped, %0d overflowed; %s %0d cycles.",
			predictor.status_seen[ST_MAPPED], predictor.status_seen[ST_UNMAPPED],
			predictor.status_seen[ST_OVERFLOW], "responses held off", hold_off_total);
		if (predictor.faults == 0 && predictor.outstanding() == 0)
			$display("section_rva_translator regression: pass");
		else
			$display("section_rva_translator regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
src/srt_pkg.sv
src/srt_ifs.sv
src/srt_table.sv
src/srt_resolve.sv
src/section_rva_translator.sv
bench/tb_section_rva_translator.sv
